// ===== sv/abfs_pkg.sv =====
package abfs_pkg;

	// command codes carried in s_axis_tuser
	typedef enum logic [1:0] {
		CMD_WRITE           = 2'd0,
		CMD_READ            = 2'd1,
		CMD_READ_OR_SILENCE = 2'd2,
		CMD_CLEAR           = 2'd3
	} cmd_t;

	// result word layout, lowest bit first
	localparam int unsigned RD_BYTE_LSB   = 0;
	localparam int unsigned DONE_BIT      = 8;
	localparam int unsigned FILL_LSB      = 9;
	localparam int unsigned FILL_W        = 13;
	localparam int unsigned OVERRUN_LSB   = 22;
	localparam int unsigned UNDERRUN_LSB  = 54;
	localparam int unsigned TOT_WR_LSB    = 86;
	localparam int unsigned TOT_RD_LSB    = 118;
	localparam int unsigned CNT_W         = 32;
	localparam int unsigned OUT_W         = 152;

	localparam int unsigned CAP_W = 13;

endpackage

// ===== sv/abfs_ram.sv =====
module abfs_ram #(
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [7:0]               wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [7:0]               rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/audio_byte_fifo_with_stats_unit.sv =====
// audio byte ring buffer with overrun, underrun and byte counters
// path: an accepted word is registered in stage 1 while the ram read is done, then in the output register
// throughput: one word per cycle unless m_axis stalls; the store is a one-write-port ram with
//   one read port and registered read data; pointers and counters update in the accept cycle
// reset (arst_n low): pointers, fill count, all counters and the short-call flag go to 0,
//   capacity returns to DEPTH; store contents are not cleared and no clearing pass is run
module audio_byte_fifo_with_stats_unit #(
	parameter int unsigned DEPTH = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// capacity register
	input  logic                         cfg_wr_en,
	input  logic [abfs_pkg::CAP_W-1:0]   cfg_wr_data,
	// input words
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,  // wr_byte
	input  logic [1:0]                   s_axis_tuser,  // cmd
	input  logic                         s_axis_tlast,  // burst_end
	// result words
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// rd_byte[7:0], done_res[8], fill_level[21:9], overrun_count[53:22],
	// underrun_count[85:54], total_written[117:86], total_read[149:118], zero pad[151:150]
	output logic [abfs_pkg::OUT_W-1:0]   m_axis_tdata
);

	localparam int unsigned PW = $clog2(DEPTH);     // pointer width
	localparam int unsigned CW = $clog2(DEPTH + 1); // fill count width

	// capacity register, reset value wraps to 13 bits like the register itself
	logic [abfs_pkg::CAP_W-1:0] cap_q;

	// ring control state
	logic [PW-1:0] wr_pos_q, rd_pos_q;
	logic [CW-1:0] held_q;
	logic [31:0]   overruns_q, underruns_q, bytes_in_q, bytes_out_q;
	logic          short_q;

	// next values
	logic [PW-1:0] wr_pos_d, rd_pos_d;
	logic [CW-1:0] held_d;
	logic [31:0]   overruns_d, underruns_d, bytes_in_d, bytes_out_d;
	logic          short_d;

	abfs_pkg::cmd_t cmd;
	logic           is_wr, is_rd, is_clr;
	logic [31:0]    ring_len;
	logic           full, empty, ok, short_any;
	logic           accept;
	logic [31:0]    wr_next32, rd_next32, fill32;

	// stage 1: waiting for the ram read
	logic        vld_s1;
	logic        rd_en_s1;
	logic        done_s1;
	logic [abfs_pkg::FILL_W-1:0] fill_s1;
	logic [31:0] overruns_s1, underruns_s1, bytes_in_s1, bytes_out_s1;
	logic        s1_move;

	// output register
	logic                      out_vld_q;
	logic [abfs_pkg::OUT_W-1:0] out_data_q;

	logic [7:0] ram_rdata;
	logic       ram_we, ram_re;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= abfs_pkg::CAP_W'(DEPTH);
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// ring length: zero acts as one, anything past the store acts as the store size
	always_comb begin
		if (cap_q == '0) begin
			ring_len = 32'd1;
		end else if (32'(cap_q) > 32'(DEPTH)) begin
			ring_len = 32'(DEPTH);
		end else begin
			ring_len = 32'(cap_q);
		end
	end

	assign cmd    = abfs_pkg::cmd_t'(s_axis_tuser);
	assign accept = s_axis_tvalid && s_axis_tready;

	always_comb begin
		is_wr  = 1'b0;
		is_rd  = 1'b0;
		is_clr = 1'b0;
		case (cmd)
			abfs_pkg::CMD_WRITE:           is_wr  = 1'b1;
			abfs_pkg::CMD_READ:            is_rd  = 1'b1;
			abfs_pkg::CMD_READ_OR_SILENCE: is_rd  = 1'b1;
			abfs_pkg::CMD_CLEAR:           is_clr = 1'b1;
			default:                       is_clr = 1'b0;
		endcase
	end

	// full while held count reaches the ring length, even after a capacity shrink
	assign full  = 32'(held_q) >= ring_len;
	assign empty = (held_q == '0);
	assign ok    = (is_wr && !full) || (is_rd && !empty);

	// pointers wrap once the next value reaches the ring length
	assign wr_next32 = 32'(wr_pos_q) + 32'd1;
	assign rd_next32 = 32'(rd_pos_q) + 32'd1;

	assign short_any = short_q || !ok;

	always_comb begin
		wr_pos_d    = wr_pos_q;
		rd_pos_d    = rd_pos_q;
		held_d      = held_q;
		overruns_d  = overruns_q;
		underruns_d = underruns_q;
		bytes_in_d  = bytes_in_q;
		bytes_out_d = bytes_out_q;
		short_d     = short_q;
		if (is_clr) begin
			wr_pos_d    = '0;
			rd_pos_d    = '0;
			held_d      = '0;
			overruns_d  = '0;
			underruns_d = '0;
			bytes_in_d  = '0;
			bytes_out_d = '0;
			short_d     = 1'b0;
		end else begin
			if (is_wr && ok) begin
				wr_pos_d   = (wr_next32 >= ring_len) ? '0 : wr_next32[PW-1:0];
				held_d     = held_q + CW'(1);
				bytes_in_d = bytes_in_q + 32'd1;
			end
			if (is_rd && ok) begin
				rd_pos_d    = (rd_next32 >= ring_len) ? '0 : rd_next32[PW-1:0];
				held_d      = held_q - CW'(1);
				bytes_out_d = bytes_out_q + 32'd1;
			end
			// end of a call: charge any shortfall to the last word's command
			if (s_axis_tlast) begin
				if (short_any && is_wr) begin
					overruns_d = overruns_q + 32'd1;
				end
				if (short_any && is_rd) begin
					underruns_d = underruns_q + 32'd1;
				end
				short_d = 1'b0;
			end else begin
				short_d = short_any;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pos_q    <= '0;
			rd_pos_q    <= '0;
			held_q      <= '0;
			overruns_q  <= '0;
			underruns_q <= '0;
			bytes_in_q  <= '0;
			bytes_out_q <= '0;
			short_q     <= 1'b0;
		end else if (accept) begin
			wr_pos_q    <= wr_pos_d;
			rd_pos_q    <= rd_pos_d;
			held_q      <= held_d;
			overruns_q  <= overruns_d;
			underruns_q <= underruns_d;
			bytes_in_q  <= bytes_in_d;
			bytes_out_q <= bytes_out_d;
			short_q     <= short_d;
		end
	end

	// a write lands at the edge, so a read of the same entry one word later sees it
	assign ram_we = accept && is_wr && ok;
	assign ram_re = accept && is_rd && ok;

	abfs_ram #(
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_pos_q),
		.wdata (s_axis_tdata),
		.re    (ram_re),
		.raddr (rd_pos_q),
		.rdata (ram_rdata)
	);

	assign fill32 = 32'(held_d);

	// stage 1 advances whenever the output register is free or draining
	assign s1_move       = vld_s1 && (!out_vld_q || m_axis_tready);
	assign s_axis_tready = !vld_s1 || s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (s1_move) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_en_s1     <= ram_re;
			done_s1      <= ok;
			fill_s1      <= fill32[abfs_pkg::FILL_W-1:0];
			overruns_s1  <= overruns_d;
			underruns_s1 <= underruns_d;
			bytes_in_s1  <= bytes_in_d;
			bytes_out_s1 <= bytes_out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_move) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	// rd_byte is zero unless the store was actually read
	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_data_q <= {2'b00, bytes_out_s1, bytes_in_s1, underruns_s1, overruns_s1,
				fill_s1, done_s1, (rd_en_s1 ? ram_rdata : 8'd0)};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ===== sv/abfs_chk.sv =====
module abfs_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_axis_tvalid,
	input logic                       s_axis_tready,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [abfs_pkg::OUT_W-1:0] m_axis_tdata
);

	logic [1:0] pend_q;
	logic       in_acc, out_acc;
	logic [31:0] tot_wr, tot_rd, diff;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign tot_wr  = m_axis_tdata[abfs_pkg::TOT_WR_LSB +: abfs_pkg::CNT_W];
	assign tot_rd  = m_axis_tdata[abfs_pkg::TOT_RD_LSB +: abfs_pkg::CNT_W];
	assign diff    = tot_wr - tot_rd;

	// words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// no result without an accepted word behind it, and at most two in flight
	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid |-> pend_q != 2'd0) && (pend_q != 2'd3))
		else $error("result word count does not match accepted words");

	// a result word with done_res low carries a zero rd_byte
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[abfs_pkg::DONE_BIT] |->
		m_axis_tdata[abfs_pkg::RD_BYTE_LSB +: 8] == 8'd0)
		else $error("rd_byte not zero without a store read");

	// fill level tracks bytes in minus bytes out since the last clear
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		m_axis_tdata[abfs_pkg::FILL_LSB +: abfs_pkg::FILL_W] == diff[abfs_pkg::FILL_W-1:0])
		else $error("fill level disagrees with byte totals");

endmodule

bind audio_byte_fifo_with_stats_unit abfs_chk u_abfs_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== tb/audio_byte_fifo_with_stats_unit_tb.sv =====
module audio_byte_fifo_with_stats_unit_tb;

	localparam int unsigned DEPTH       = 4096;
	localparam int unsigned IDLE_LIMIT  = 2000;  // cycles with no word moving on either side
	localparam int unsigned HOLD_CYCLES = 300;   // long receiver hold-off
	localparam int unsigned TAIL_CYCLES = 8;     // settle time after the last result word
	localparam int unsigned PHASE_WORDS = 95;
	localparam int unsigned EDGE_RING   = 24;    // ring length for the run past both ends

	// one result word, field by field
	typedef struct {
		logic [7:0]  rd_byte;
		logic        done_res;
		logic [12:0] fill_level;
		logic [31:0] overrun_count;
		logic [31:0] underrun_count;
		logic [31:0] total_written;
		logic [31:0] total_read;
	} fifo_status_t;

	// ring buffer predictor plus the queue of status words it has produced
	class byte_fifo_scoreboard;
		logic [7:0]                 ring [DEPTH];
		bit                         ring_valid [DEPTH];
		logic [abfs_pkg::CAP_W-1:0] capacity;
		int unsigned                wr_ptr;
		int unsigned                rd_ptr;
		int unsigned                fill;
		logic [31:0]                overruns;
		logic [31:0]                underruns;
		logic [31:0]                bytes_in;
		logic [31:0]                bytes_out;
		bit                         call_short;
		fifo_status_t               status_q [$];
		int unsigned                errors;

		function new();
			capacity = abfs_pkg::CAP_W'(DEPTH);
			errors = 0;
			clear_counts();
		endfunction

		function void clear_counts();
			wr_ptr = 0;
			rd_ptr = 0;
			fill = 0;
			overruns = '0;
			underruns = '0;
			bytes_in = '0;
			bytes_out = '0;
			call_short = 1'b0;
		endfunction

		// register value 0 acts as 1, anything above the store size as the store size
		function int unsigned ring_len();
			int unsigned c;
			c = capacity;
			if (c == 0) c = 1;
			if (c > DEPTH) c = DEPTH;
			return c;
		endfunction

		function int unsigned step_ptr(int unsigned p);
			return (p + 1 >= ring_len()) ? 0 : p + 1;
		endfunction

		// a read now would land on a store entry that was never written
		function bit read_hits_unwritten();
			return fill > 0 && !ring_valid[rd_ptr];
		endfunction

		function int unsigned outstanding();
			return status_q.size();
		endfunction

		function void note_word(abfs_pkg::cmd_t cmd, logic [7:0] wr_byte, logic last);
			fifo_status_t s;
			bit ok;
			s.rd_byte = 8'h00;
			s.done_res = 1'b0;
			if (cmd == abfs_pkg::CMD_CLEAR) begin
				clear_counts();
			end else begin
				if (cmd == abfs_pkg::CMD_WRITE) begin
					ok = fill < ring_len();
					if (ok) begin
						ring[wr_ptr] = wr_byte;
						ring_valid[wr_ptr] = 1'b1;
						wr_ptr = step_ptr(wr_ptr);
						fill++;
						bytes_in++;
					end
				end else begin
					ok = fill > 0;
					if (ok) begin
						s.rd_byte = ring[rd_ptr];
						rd_ptr = step_ptr(rd_ptr);
						fill--;
						bytes_out++;
					end
				end
				s.done_res = ok;
				if (!ok) call_short = 1'b1;
				if (last) begin
					// a short call is charged to the command of its last word
					if (call_short) begin
						if (cmd == abfs_pkg::CMD_WRITE) overruns++;
						else underruns++;
					end
					call_short = 1'b0;
				end
			end
			s.fill_level = 13'(fill);
			s.overrun_count = overruns;
			s.underrun_count = underruns;
			s.total_written = bytes_in;
			s.total_read = bytes_out;
			status_q.push_back(s);
		endfunction

		function void check_field(string field, logic [31:0] exp_val, logic [31:0] act_val);
			if (act_val !== exp_val) begin
				$error("%s mismatch: expected %0d, got %0d", field, exp_val, act_val);
				errors++;
			end
		endfunction

		function void check_status(logic [abfs_pkg::OUT_W-1:0] w);
			fifo_status_t e;
			if (status_q.size() == 0) begin
				$error("result word with no status expected: %h", w);
				errors++;
				return;
			end
			e = status_q.pop_front();
			check_field("rd_byte", e.rd_byte, w[abfs_pkg::RD_BYTE_LSB +: 8]);
			check_field("done_res", e.done_res, w[abfs_pkg::DONE_BIT]);
			check_field("fill_level", e.fill_level,
				w[abfs_pkg::FILL_LSB +: abfs_pkg::FILL_W]);
			check_field("overrun_count", e.overrun_count,
				w[abfs_pkg::OVERRUN_LSB +: abfs_pkg::CNT_W]);
			check_field("underrun_count", e.underrun_count,
				w[abfs_pkg::UNDERRUN_LSB +: abfs_pkg::CNT_W]);
			check_field("total_written", e.total_written,
				w[abfs_pkg::TOT_WR_LSB +: abfs_pkg::CNT_W]);
			check_field("total_read", e.total_read,
				w[abfs_pkg::TOT_RD_LSB +: abfs_pkg::CNT_W]);
		endfunction
	endclass

	// clock, reset and block ports; every input starts at a known value
	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_wr_en = 1'b0;
	logic [abfs_pkg::CAP_W-1:0] cfg_wr_data = '0;
	logic                       s_axis_tvalid = 1'b0;
	logic                       s_axis_tready;
	logic [7:0]                 s_axis_tdata = '0;   // wr_byte
	logic [1:0]                 s_axis_tuser = '0;   // cmd
	logic                       s_axis_tlast = 1'b0; // burst_end
	logic                       m_axis_tvalid;
	logic                       m_axis_tready = 1'b0;
	// rd_byte, done_res, fill_level, overrun_count, underrun_count,
	// total_written, total_read, zero pad
	logic [abfs_pkg::OUT_W-1:0] m_axis_tdata;

	byte_fifo_scoreboard sb;

	// idling knobs: the sender's is used by the main process only, the
	// receiver's ones change by nonblocking writes so the sampling edge is clean
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	logic        rx_hold = 1'b0;
	int unsigned words_sent = 0;
	int unsigned quiet_cycles = 0;

	always #5 clk = ~clk;

	audio_byte_fifo_with_stats_unit #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// receiver: random stalls, or held off completely while rx_hold is up
	always @(posedge clk) begin
		if (!arst_n) m_axis_tready <= 1'b0;
		else if (rx_hold) m_axis_tready <= 1'b0;
		else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// result checking and the no-progress watchdog, both on pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) sb.check_status(m_axis_tdata);
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= IDLE_LIMIT) begin
				$display("** audio_byte_fifo_with_stats_unit: FAILED **");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// drop valid and wait on the clock; n must be nonzero, so valid is never written twice in one step
	task automatic go_idle(int unsigned n);
		s_axis_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// offer one word, optionally after a random gap, and note it once it is taken
	task automatic send_word(abfs_pkg::cmd_t cmd, logic [7:0] wr_byte, logic last);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
		if (gap != 0) go_idle(gap);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= wr_byte;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_word(cmd, wr_byte, last);
		words_sent++;
	endtask

	// sender pauses until every expected status word has come back
	task automatic wait_drained();
		go_idle(1);
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// capacity changes only on an idle block
	task automatic set_capacity(logic [abfs_pkg::CAP_W-1:0] value);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.capacity = value;
	endtask

	task automatic hold_receiver();
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	endtask

	// a read that would hit a never-written entry is turned into a write
	function automatic abfs_pkg::cmd_t keep_defined(abfs_pkg::cmd_t cmd);
		if ((cmd == abfs_pkg::CMD_READ || cmd == abfs_pkg::CMD_READ_OR_SILENCE) &&
			sb.read_hits_unwritten())
			return abfs_pkg::CMD_WRITE;
		return cmd;
	endfunction

	// one software call: mostly well-formed write or read bursts, some mixed,
	// some clears and some stray words with a random last flag
	task automatic send_random_call();
		int unsigned kind;
		int unsigned len;
		abfs_pkg::cmd_t cmd;
		kind = $urandom_range(99);
		len = $urandom_range(6, 1);
		if (kind < 5) begin
			send_word(abfs_pkg::CMD_CLEAR, 8'($urandom), 1'($urandom));
		end else if (kind < 15) begin
			send_word(keep_defined(abfs_pkg::cmd_t'($urandom_range(3))), 8'($urandom),
				1'($urandom));
		end else begin
			for (int i = 0; i < len; i++) begin
				if (kind < 55) cmd = abfs_pkg::CMD_WRITE;
				else if (kind < 90)
					cmd = $urandom_range(1) ? abfs_pkg::CMD_READ :
						abfs_pkg::CMD_READ_OR_SILENCE;
				else cmd = abfs_pkg::cmd_t'($urandom_range(2));
				send_word(keep_defined(cmd), 8'($urandom), i == len - 1);
			end
		end
	endtask

	initial begin
		logic [abfs_pkg::CAP_W-1:0] cap_list [8];
		int unsigned target;
		cap_list = '{13'd3, 13'd1, 13'd16, 13'd0, 13'd8191, 13'd5, 13'd2, 13'd40};
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reads from an empty ring, plain and read-or-silence, over one and two words
		send_word(abfs_pkg::CMD_READ, 8'h00, 1'b1);
		send_word(abfs_pkg::CMD_READ_OR_SILENCE, 8'hFF, 1'b0);
		send_word(abfs_pkg::CMD_READ_OR_SILENCE, 8'h00, 1'b1);
		// byte extremes in and out again
		send_word(abfs_pkg::CMD_WRITE, 8'h00, 1'b0);
		send_word(abfs_pkg::CMD_WRITE, 8'hFF, 1'b0);
		send_word(abfs_pkg::CMD_WRITE, 8'hA5, 1'b1);
		send_word(abfs_pkg::CMD_READ, 8'h00, 1'b0);
		send_word(abfs_pkg::CMD_READ_OR_SILENCE, 8'h00, 1'b1);
		// clear with the last flag set, which it ignores
		send_word(abfs_pkg::CMD_CLEAR, 8'hFF, 1'b1);

		// register 0 acts as a one-byte ring: second write overruns
		set_capacity(13'd0);
		send_word(abfs_pkg::CMD_WRITE, 8'h5A, 1'b0);
		send_word(abfs_pkg::CMD_WRITE, 8'hC3, 1'b1);
		// mixed call: the dropped write makes it short, the read at its end takes the charge
		send_word(abfs_pkg::CMD_WRITE, 8'h3C, 1'b0);
		send_word(abfs_pkg::CMD_READ, 8'h00, 1'b1);

		// all ones acts as the full store size
		set_capacity(13'd8191);
		send_word(abfs_pkg::CMD_CLEAR, 8'h00, 1'b0);

		// shrink the ring down to the fill level while bytes are held
		set_capacity(13'd8);
		for (int i = 0; i < 6; i++)
			send_word(abfs_pkg::CMD_WRITE, 8'(8'h11 * (i + 1)), i == 5);
		send_word(abfs_pkg::CMD_READ, 8'h00, 1'b0);
		send_word(abfs_pkg::CMD_READ, 8'h00, 1'b1);
		set_capacity(13'd4);
		send_word(abfs_pkg::CMD_WRITE, 8'h77, 1'b1);
		for (int i = 0; i < 4; i++) send_word(abfs_pkg::CMD_READ_OR_SILENCE, 8'h00, i == 3);

		// random calls over several capacities and idling patterns
		for (int p = 0; p < 8; p++) begin
			if (p == 7) set_capacity(13'($urandom_range(40, 1)));
			else set_capacity(cap_list[p]);
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct = 78;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct <= 78;
				end
				default: begin
					send_idle_pct = 15;
					recv_stall_pct <= 15;
				end
			endcase
			// back-pressure: receiver stops while the sender keeps offering
			if (p == 0) begin
				fork
					hold_receiver();
				join_none
			end
			target = words_sent + PHASE_WORDS;
			while (words_sent < target) begin
				send_random_call();
				// mid-phase sender pause until everything is back
				if (p == 2 && words_sent >= target - PHASE_WORDS / 2 && sb.outstanding() != 0)
					wait_drained();
			end
		end

		// small ring: one write and one read past each end
		set_capacity(13'(EDGE_RING));
		send_idle_pct = 0;
		recv_stall_pct <= 15;
		send_word(abfs_pkg::CMD_CLEAR, 8'h00, 1'b0);
		for (int i = 0; i <= EDGE_RING; i++)
			send_word(abfs_pkg::CMD_WRITE, 8'($urandom), (i % 8 == 7) || i == EDGE_RING);
		for (int i = 0; i <= EDGE_RING; i++)
			send_word(i % 2 ? abfs_pkg::CMD_READ : abfs_pkg::CMD_READ_OR_SILENCE,
				8'($urandom), (i % 8 == 7) || i == EDGE_RING);

		wait_drained();
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("** audio_byte_fifo_with_stats_unit: PASSED **");
		end else begin
			$display("** audio_byte_fifo_with_stats_unit: FAILED **");
		end
		$finish;
	end

endmodule
